[design/deq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, operation and status codes, and the cell control bundle
// for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    // levels of the back-end select tree, and its padded leaf count
    localparam int LVL        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEAVES     = 2 ** LVL;
    localparam int WAIT_W     = $clog2(LVL + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                  shift_up;    // push front: every cell takes its lower neighbor
        logic                  shift_down;  // pop front: every cell takes its upper neighbor
        logic                  load_back;   // push back: the cell at position count loads
        logic [WORD_WIDTH-1:0] push_value;
        logic [CNT_W-1:0]      count;       // count before this beat
    } t_cell_ctl;

endpackage : deq_pkg
`default_nettype wire

[design/deq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_cell
// One queue slot. Holds element number i_index counted from the front,
// shifts with its neighbors on front operations, and gates its word onto
// the back tap when it holds the last element.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [IDX_W-1:0]      i_index,
    input  wire logic [WORD_WIDTH-1:0] i_prev_data,
    input  wire logic [WORD_WIDTH-1:0] i_next_data,
    output logic      [WORD_WIDTH-1:0] o_data,
    output logic      [WORD_WIDTH-1:0] o_tap
);

    logic [WORD_WIDTH-1:0] r_data;
    logic [WORD_WIDTH-1:0] n_data;
    logic [CNT_W-1:0]      w_pos;
    logic                  w_is_last;

    assign w_pos     = CNT_W'(i_index);
    assign w_is_last = (w_pos + CNT_W'(1)) == i_ctl.count;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            n_data = i_prev_data;
        end else if (i_ctl.shift_down) begin
            n_data = i_next_data;
        end else if (i_ctl.load_back && (w_pos == i_ctl.count)) begin
            n_data = i_ctl.push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_is_last ? r_data : '0;

endmodule : deq_cell
`default_nettype wire

[design/deq_or_tree.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_or_tree
// Registered OR tree over the cell taps: the taps are registered, and so is
// every level above them. At most one tap is nonzero, so the root carries
// the back element once the taps have passed through every level.
// ----------------------------------------------------------------------------
module deq_or_tree
    import deq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [WORD_WIDTH-1:0] i_leaf [DEPTH],
    output logic      [WORD_WIDTH-1:0] o_root
);

    // heap order: node 1 is the root, leaves sit at LEAVES .. 2*LEAVES-1
    logic [WORD_WIDTH-1:0] r_node [1:2*LEAVES-1];

    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        always_ff @(posedge i_clk) begin
            if (k < DEPTH) begin
                r_node[LEAVES + k] <= i_leaf[k];
            end else begin
                r_node[LEAVES + k] <= '0;
            end
        end
    end

    for (genvar k = 1; k < LEAVES; k++) begin : g_node
        always_ff @(posedge i_clk) begin
            r_node[k] <= r_node[2 * k] | r_node[2 * k + 1];
        end
    end

    assign o_root = r_node[1];

endmodule : deq_or_tree
`default_nettype wire

[design/double_ended_queue_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage
//   Command beat: raise start with i_operation and i_push_value; the beat is
//   taken on a rising edge where start is high and busy is low.
//   Result beat: o_valid is high for exactly one cycle with o_status,
//   o_peek_value and o_element_count. The receiver cannot stall it.
//   Storage: cell i holds the element i places from the front. Front pushes
//   and pops shift the whole row by one cell; a back push loads the cell at
//   position count; a back pop only lowers the count.
//   Latency / throughput:
//     - push, pop, peek front, any empty or full case, unknown codes:
//       result in the cycle after the beat, busy stays low, one beat a cycle while busy is low.
//     - peek back on a nonempty queue: the last cell's word goes through a
//       registered OR tree of LVL levels (6 at 64 entries); busy stays high
//       until the root is taken as the result, and no new beat is taken meanwhile.
//   Reset (synchronous, active low): count zero, queue empty, busy low, no
//   result pending. Cell contents are not cleared; they are read only after
//   being written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic        [2:0]            i_operation,
    input  wire logic signed [WORD_WIDTH-1:0] i_push_value,
    output logic                              o_valid,
    output logic             [1:0]            o_status,
    output logic signed      [WORD_WIDTH-1:0] o_peek_value,
    output logic             [CNT_W-1:0]      o_element_count
);

    // ---- state ----
    logic [CNT_W-1:0]      r_count,  n_count;
    logic                  r_busy,   n_busy;
    logic [WAIT_W-1:0]     r_wait,   n_wait;
    logic                  r_valid,  n_valid;
    t_status               r_status, n_status;
    logic [WORD_WIDTH-1:0] r_value,  n_value;
    logic [CNT_W-1:0]      r_ocount, n_ocount;

    // ---- cell row ----
    t_cell_ctl             w_ctl;
    logic [WORD_WIDTH-1:0] w_data [DEPTH];
    logic [WORD_WIDTH-1:0] w_tap  [DEPTH];
    logic [WORD_WIDTH-1:0] w_root;

    logic                  w_accept;
    logic                  w_empty;
    logic                  w_full;
    t_op                   w_op;

    assign w_accept = start && !r_busy;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_op     = t_op'(i_operation);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_prev;
        logic [WORD_WIDTH-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_ctl.push_value;
        end else begin : g_mid
            assign w_prev = w_data[g - 1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_up
            assign w_next = w_data[g + 1];
        end
        deq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_index     (IDX_W'(g)),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .o_data      (w_data[g]),
            .o_tap       (w_tap[g])
        );
    end

    deq_or_tree u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_tap),
        .o_root (w_root)
    );

    // ---- command decode ----
    always_comb begin
        w_ctl.shift_up   = 1'b0;
        w_ctl.shift_down = 1'b0;
        w_ctl.load_back  = 1'b0;
        w_ctl.push_value = i_push_value;
        w_ctl.count      = r_count;

        n_count  = r_count;
        n_busy   = r_busy;
        n_wait   = r_wait;
        n_valid  = 1'b0;
        n_status = r_status;
        n_value  = r_value;
        n_ocount = r_ocount;

        if (r_busy) begin
            // waiting on the back tree; state is frozen meanwhile
            if (r_wait == '0) begin
                n_busy   = 1'b0;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_value  = w_root;
                n_ocount = r_count;
            end else begin
                n_wait = r_wait - WAIT_W'(1);
            end
        end else if (w_accept) begin
            n_valid  = 1'b1;
            n_status = ST_OK;
            n_value  = '0;
            case (w_op)
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.shift_up = 1'b1;
                        n_count        = r_count + CNT_W'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.load_back = 1'b1;
                        n_count         = r_count + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.shift_down = 1'b1;
                        n_count          = r_count - CNT_W'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_PEEK_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_value = w_data[0];
                    end
                end
                OP_PEEK_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // result comes from the tree later
                        n_valid = 1'b0;
                        n_busy  = 1'b1;
                        n_wait  = WAIT_W'(LVL);
                    end
                end
                default: begin
                    // unknown code: no change, ok status
                end
            endcase
            n_ocount = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_wait  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
            r_wait  <= n_wait;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_ocount <= n_ocount;
    end

    assign busy            = r_busy;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_peek_value    = r_value;
    assign o_element_count = r_ocount;

    // ---- checks ----
    a_peek_back_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_PEEK_BACK && r_count != '0) |=> busy)
        else $error("peek back on nonempty queue did not raise busy");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_wait != '0) |=> !o_valid)
        else $error("result strobe while tree still settling");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_element_count == CNT_W'(DEPTH)))
        else $error("full status with count below depth");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_element_count == '0 && o_peek_value == '0))
        else $error("empty status with nonzero count or value");

endmodule : double_ended_queue_unit
`default_nettype wire

[tb/sv/tb_double_ended_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Drives operation beats into the double-ended queue and checks every result
// beat against a ring-buffer prediction kept in the bench. A short directed
// run covers empty, reserved-code and extreme-word cases. Random segments
// follow, biased to fill, drain, mix or send noise, so that full and empty
// are both reached many times. Sender gaps change from phase to phase.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
    import deq_pkg::*;

    // codes 6 and 7 are not operations; the block must ignore them
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam int RANDOM_BEATS = 1150;
    localparam int PHASE_BEATS  = 200;

    typedef struct {
        logic [2:0]                   op;
        logic signed [WORD_WIDTH-1:0] word;
        int                           idle_pct;  // chance per cycle of holding the beat back
    } t_op_beat;

    typedef struct {
        t_status                      status;
        logic signed [WORD_WIDTH-1:0] value;
        logic [CNT_W-1:0]             count;
    } t_deque_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [2:0]                   i_operation;
    logic signed [WORD_WIDTH-1:0] i_push_value;
    logic                         o_valid;
    logic [1:0]                   o_status;
    logic signed [WORD_WIDTH-1:0] o_peek_value;
    logic [CNT_W-1:0]             o_element_count;

    t_op_beat      op_backlog[$];     // beats still to be sent
    t_deque_result deque_answers[$];  // predicted results, oldest first
    int            fail_count = 0;

    // bench copy of the deque
    logic signed [WORD_WIDTH-1:0] ring_words [DEPTH];
    int                           front_slot = 0;
    int                           back_slot  = 0;  // one past the back element
    int                           held       = 0;

    double_ended_queue_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_push_value    (i_push_value),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_peek_value    (o_peek_value),
        .o_element_count (o_element_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Apply one operation to the bench deque and queue the result it gives.
    task automatic apply_deque_op(input logic [2:0] op, input logic signed [WORD_WIDTH-1:0] word);
        t_deque_result r;
        r.status = ST_OK;
        r.value  = '0;
        case (op)
            OP_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_slot = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
                    ring_words[front_slot] = word;
                    held++;
                end
            end
            OP_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_words[back_slot] = word;
                    back_slot = (back_slot == DEPTH - 1) ? 0 : back_slot + 1;
                    held++;
                end
            end
            OP_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    front_slot = (front_slot == DEPTH - 1) ? 0 : front_slot + 1;
                    held--;
                end
            end
            OP_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    back_slot = (back_slot == 0) ? DEPTH - 1 : back_slot - 1;
                    held--;
                end
            end
            OP_PEEK_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = ring_words[front_slot];
                end
            end
            OP_PEEK_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = ring_words[(back_slot == 0) ? DEPTH - 1 : back_slot - 1];
                end
            end
            default: ;  // reserved code: nothing moves
        endcase
        r.count = CNT_W'(held);
        deque_answers.push_back(r);
    endtask

    // Words lean on the extremes now and then; the rest are uniform.
    function automatic logic signed [WORD_WIDTH-1:0] pick_word();
        case ($urandom_range(9))
            0:       pick_word = {1'b0, {(WORD_WIDTH-1){1'b1}}};
            1:       pick_word = {1'b1, {(WORD_WIDTH-1){1'b0}}};
            2:       pick_word = '0;
            3:       pick_word = '1;
            default: pick_word = WORD_WIDTH'($urandom);
        endcase
    endfunction

    task automatic add_beat(input logic [2:0] op, input logic signed [WORD_WIDTH-1:0] word,
                            input int idle_pct);
        t_op_beat b;
        b.op       = op;
        b.word     = word;
        b.idle_pct = idle_pct;
        op_backlog.push_back(b);
    endtask

    // ------------------------------------------------------------------------
    // Driver. A beat counts at an edge where start is high and busy low; the
    // prediction is made right there from the values being presented. Start
    // gets a single assignment per edge, so a beat followed at once by the
    // next one keeps start high without a glitch.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_op_beat nb;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_deque_op(i_operation, i_push_value);
            end
            // free to present the next beat once the current one is taken
            if (!start || !busy) begin
                if (op_backlog.size() > 0 && $urandom_range(99) >= op_backlog[0].idle_pct) begin
                    nb = op_backlog.pop_front();
                    start        <= 1'b1;
                    i_operation  <= nb.op;
                    i_push_value <= nb.word;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. o_valid marks a result for exactly one cycle; it is taken at
    // the edge that ends that cycle and matched with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_deque_result exp_r;
        if (i_rst_n && o_valid) begin
            if (deque_answers.size() == 0) begin
                $display("%0t unexpected result beat: status %0d, value %0d, count %0d",
                         $time, o_status, o_peek_value, o_element_count);
                fail_count++;
            end else begin
                exp_r = deque_answers.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, exp_r.status, o_status);
                    fail_count++;
                end
                if (o_peek_value !== exp_r.value) begin
                    $display("%0t peek value mismatch: expected %0d, actual %0d",
                             $time, exp_r.value, o_peek_value);
                    fail_count++;
                end
                if (o_element_count !== exp_r.count) begin
                    $display("%0t element count mismatch: expected %0d, actual %0d",
                             $time, exp_r.count, o_element_count);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int     n;
        int     seg_len;
        int     mode;
        int     r;
        int     pct;
        int     gap_pcts[3];
        logic [2:0] op;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = OP_PUSH_FRONT;
        i_push_value = '0;
        gap_pcts     = '{0, 84, 29};

        // directed: empty cases, reserved codes, extreme words at both ends
        add_beat(OP_PEEK_FRONT, '0, 0);
        add_beat(OP_PEEK_BACK,  '1, 0);
        add_beat(OP_POP_FRONT,  '0, 0);
        add_beat(OP_POP_BACK,   '0, 0);
        add_beat(OP_RSVD_6,     '1, 0);
        add_beat(OP_RSVD_7,     '0, 0);
        add_beat(OP_PUSH_BACK,  {1'b0, {(WORD_WIDTH-1){1'b1}}}, 0);
        add_beat(OP_PUSH_FRONT, {1'b1, {(WORD_WIDTH-1){1'b0}}}, 0);
        add_beat(OP_PEEK_FRONT, '0, 0);
        add_beat(OP_PEEK_BACK,  '0, 0);
        add_beat(OP_PUSH_BACK,  '0, 0);
        add_beat(OP_PUSH_FRONT, '1, 0);
        add_beat(OP_PEEK_BACK,  '0, 0);
        add_beat(OP_PEEK_FRONT, '0, 0);
        add_beat(OP_RSVD_7,     '1, 0);   // reserved code with a nonempty queue
        add_beat(OP_POP_BACK,   '0, 0);
        add_beat(OP_PEEK_BACK,  '0, 0);
        add_beat(OP_POP_FRONT,  '0, 0);
        add_beat(OP_PEEK_FRONT, '0, 0);
        add_beat(OP_POP_FRONT,  '0, 0);
        add_beat(OP_POP_BACK,   '0, 0);   // last element gone
        add_beat(OP_POP_BACK,   '0, 0);
        add_beat(OP_PUSH_FRONT, 32'sh5555_5555, 0);
        add_beat(OP_PEEK_BACK,  '0, 0);
        add_beat(OP_POP_FRONT,  '0, 0);

        // random segments; the first one is biased to fill the queue
        n    = 0;
        mode = 0;
        while (n < RANDOM_BEATS) begin
            seg_len = (mode == 0) ? $urandom_range(100, 60) : $urandom_range(90, 20);
            for (int k = 0; k < seg_len && n < RANDOM_BEATS; k++) begin
                pct = gap_pcts[(n / PHASE_BEATS) % 3];
                r   = $urandom_range(99);
                case (mode)
                    0:  // fill: mostly pushes
                        op = (r < 88) ? 3'($urandom_range(1)) : 3'($urandom_range(5, 2));
                    1:  // drain: mostly pops
                        op = (r < 85) ? 3'($urandom_range(3, 2)) : 3'($urandom_range(5));
                    2:  // mixed legal operations
                        op = 3'($urandom_range(5));
                    default:  // noise, reserved codes included
                        op = 3'($urandom_range(7));
                endcase
                add_beat(op, pick_word(), pct);
                n++;
            end
            r    = $urandom_range(99);
            mode = (r < 30) ? 0 : (r < 55) ? 1 : (r < 85) ? 2 : 3;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all beats taken, then all results in, then a short quiet spell
        while (op_backlog.size() > 0 || start) @(posedge i_clk);
        while (deque_answers.size() > 0) @(posedge i_clk);
        repeat (LVL + 6) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** double_ended_queue_unit: PASSED **");
        end else begin
            $display("** double_ended_queue_unit: FAILED **");
        end
        $finish;
    end

    // watchdog: a hung handshake or a lost result ends here
    initial begin
        #5_000_000;
        $display("** double_ended_queue_unit: FAILED **");
        $finish;
    end

endmodule : tb_double_ended_queue_unit

[sim.f]
design/deq_pkg.sv
design/deq_cell.sv
design/deq_or_tree.sv
design/double_ended_queue_unit.sv
tb/sv/tb_double_ended_queue_unit.sv
